// ===== rtl/core/ris_pkg.sv =====
`default_nettype none

package ris_pkg;

    // One stored record: 61 bits
    typedef struct packed {
        logic signed [31:0] id;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [5:0]         tag;
    } t_rec;

    // Sort key codes
    typedef enum logic {
        KEY_ID   = 1'b0,
        KEY_DATE = 1'b1
    } t_key;

    // Per-cell load control, set by the chain controller
    typedef struct packed {
        logic take_new;   // latch the arriving record
        logic take_prev;  // shift up: latch the lower neighbor
        logic take_next;  // drain: latch the upper neighbor
    } t_cell_ctl;

    // Strict less-than under the selected key
    function automatic logic key_less(input t_rec a, input t_rec b, input t_key key);
        logic res;
        if (key == KEY_DATE) begin
            res = {a.year, a.month, a.day} < {b.year, b.month, b.day};
        end else begin
            res = a.id < b.id;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ris_cell.sv =====
`default_nettype none

module ris_cell (
    input  wire              i_clk,
    input  ris_pkg::t_cell_ctl i_ctl,
    input  ris_pkg::t_key    i_key,
    input  ris_pkg::t_rec    i_new,
    input  ris_pkg::t_rec    i_prev,
    input  ris_pkg::t_rec    i_next,
    output ris_pkg::t_rec    o_rec,
    output logic             o_new_less
);
    import ris_pkg::*;

    t_rec r_rec;

    // Arriving record sorts strictly below this entry
    assign o_new_less = key_less(i_new, r_rec, i_key);
    assign o_rec      = r_rec;

    // Entry register: insert, shift up on insert, shift down on drain
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_new) begin
            r_rec <= i_new;
        end else if (i_ctl.take_prev) begin
            r_rec <= i_prev;
        end else if (i_ctl.take_next) begin
            r_rec <= i_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/record_insertion_sorter.sv =====
`default_nettype none

// Stable insertion sorter for small records.
// Input: a record beat is taken at a rising edge with start high and busy
// low. Records load at one per cycle; each is placed in the cell chain in
// the cycle it is taken, entries above it shifting up one cell.
// The beat with i_last_record high starts the drain: busy rises the next
// cycle and the chain shifts toward cell 0, one record per cycle. Results
// appear with o_strobe for one cycle each, in ascending key order, the
// first one on the ports right after the edge that follows the last beat;
// n stored records give n result beats, and busy falls in the cycle the
// final beat (o_out_last) is shown.
// The drain rate is set by the single output port at cell 0.
// Once MAX_RECORDS records are held, further beats are dropped and
// o_overflowed is raised on every result beat of that set.
// Key select (i_cfg_we / i_cfg_data) applies to records taken after the write.
// Reset empties the store, clears the overflow flag and selects the id key.
// The receiver cannot stall: every strobed beat is consumed as shown.
module record_insertion_sorter #(
    parameter int MAX_RECORDS = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire signed [31:0]  i_student_id,
    input  wire        [13:0]  i_year,
    input  wire        [3:0]   i_month,
    input  wire        [4:0]   i_day,
    input  wire        [5:0]   i_record_tag,
    input  wire                i_last_record,
    input  wire                i_cfg_we,
    input  wire                i_cfg_data,
    output logic               o_strobe,
    output logic        [5:0]  o_out_tag,
    output logic signed [31:0] o_out_id,
    output logic        [13:0] o_out_year,
    output logic        [3:0]  o_out_month,
    output logic        [4:0]  o_out_day,
    output logic               o_overflowed,
    output logic               o_out_last
);
    import ris_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    t_key            r_key;
    t_rec            r_out;

    t_rec            new_rec;
    t_rec            cell_rec [MAX_RECORDS];
    t_cell_ctl       cell_ctl [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] new_less;
    logic [MAX_RECORDS-1:0] pass_mask;
    logic [MAX_RECORDS-1:0] at_or_above;
    logic            accept;
    logic            insert;

    assign new_rec = '{id: i_student_id, year: i_year, month: i_month,
                       day: i_day, tag: i_record_tag};

    assign busy   = (r_state == ST_DRAIN);
    assign accept = start && !busy;
    assign insert = accept && (r_count < FULL);

    // Cell chain; at_or_above[i] marks the insertion point and every cell above it
    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
            // unoccupied cells always let the new record pass
            assign pass_mask[gi]   = new_less[gi] || !(CW'(gi) < r_count);
            assign at_or_above[gi] = &pass_mask[MAX_RECORDS-1:gi];

            if (gi == 0) begin : g_bottom
                assign cell_ctl[gi].take_new  = insert && at_or_above[gi];
                assign cell_ctl[gi].take_prev = 1'b0;
            end else begin : g_upper
                assign cell_ctl[gi].take_new  = insert && at_or_above[gi]
                                                && !at_or_above[gi-1];
                assign cell_ctl[gi].take_prev = insert && at_or_above[gi-1];
            end
            assign cell_ctl[gi].take_next = busy;

            ris_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl[gi]),
                .i_key      (r_key),
                .i_new      (new_rec),
                .i_prev     ((gi == 0) ? new_rec : cell_rec[(gi == 0) ? 0 : gi-1]),
                .i_next     (cell_rec[(gi == MAX_RECORDS-1) ? gi : gi+1]),
                .o_rec      (cell_rec[gi]),
                .o_new_less (new_less[gi])
            );
        end
    endgenerate

    // Key select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_ID;
        end else if (i_cfg_we) begin
            r_key <= t_key'(i_cfg_data);
        end
    end

    // Load / drain sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (insert) begin
                            r_count <= r_count + ONE;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_record) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    o_strobe     <= 1'b1;
                    r_out        <= cell_rec[0];
                    o_overflowed <= r_ovf;
                    o_out_last   <= (r_count == ONE);
                    r_count      <= r_count - ONE;
                    if (r_count == ONE) begin
                        r_state <= ST_LOAD;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_out_tag   = r_out.tag;
    assign o_out_id    = r_out.id;
    assign o_out_year  = r_out.year;
    assign o_out_month = r_out.month;
    assign o_out_day   = r_out.day;

endmodule

`default_nettype wire

// ===== rtl/core/ris_checker.sv =====
`default_nettype none

module ris_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire i_last_record,
    input wire o_strobe,
    input wire o_out_last
);

    // A beat marked last is the one shown as busy drops
    a_last_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out_last == !busy))
        else $error("out_last does not match end of drain");

    // Taking the final record of a set starts the drain
    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_record) |=> busy)
        else $error("drain did not start after last record");

    // Every drain cycle yields one result beat
    a_drain_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("drain cycle without result beat");

    // Drain ends only with the final beat on the ports
    a_fall_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && $past(busy) && $past(i_rst_n)) |-> (o_strobe && o_out_last))
        else $error("busy fell without final beat");

endmodule

bind record_insertion_sorter ris_checker u_ris_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_last_record (i_last_record),
    .o_strobe      (o_strobe),
    .o_out_last    (o_out_last)
);

`default_nettype wire

// ===== bench/tb_record_insertion_sorter.sv =====
`timescale 1ns / 1ps

module tb_record_insertion_sorter;

    import ris_pkg::*;

    localparam int MAX_RECORDS   = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 50;
    localparam int MAX_REPORTS   = 10;

    // One sorted output beat
    typedef struct packed {
        logic [5:0]         tag;
        logic signed [31:0] id;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               ovf;
        logic               last;
    } sorted_beat_t;

    typedef enum logic {
        ROW_REC = 1'b0,
        ROW_KEY = 1'b1
    } row_kind_t;

    // Directed stimulus row: a record beat or a key register write
    typedef struct {
        row_kind_t    kind;
        t_rec         rec;
        logic         last;
        t_key         key;
        bit           typed;
        sorted_beat_t exp;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] i_student_id = '0;
    logic [13:0] i_year = '0;
    logic [3:0] i_month = '0;
    logic [4:0] i_day = '0;
    logic [5:0] i_record_tag = '0;
    logic i_last_record = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;

    logic busy;
    logic o_strobe;
    logic [5:0] o_out_tag;
    logic signed [31:0] o_out_id;
    logic [13:0] o_out_year;
    logic [3:0] o_out_month;
    logic [4:0] o_out_day;
    logic o_overflowed;
    logic o_out_last;

    record_insertion_sorter #(
        .MAX_RECORDS(MAX_RECORDS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_student_id (i_student_id),
        .i_year       (i_year),
        .i_month      (i_month),
        .i_day        (i_day),
        .i_record_tag (i_record_tag),
        .i_last_record(i_last_record),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_out_tag    (o_out_tag),
        .o_out_id     (o_out_id),
        .o_out_year   (o_out_year),
        .o_out_month  (o_out_month),
        .o_out_day    (o_out_day),
        .o_overflowed (o_overflowed),
        .o_out_last   (o_out_last)
    );

    // Sorter shadow state
    t_rec sorted_store [MAX_RECORDS];
    int   held = 0;
    logic dropped = 1'b0;
    t_key sort_key = KEY_ID;

    sorted_beat_t drain_beats [$];
    sorted_beat_t pending_sorted [$];
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Strict less-than under the current key; date folded into one number
    function automatic logic rec_below(input t_rec a, input t_rec b);
        logic [22:0] da;
        logic [22:0] db;
        da = (23'(a.year) << 9) | (23'(a.month) << 5) | 23'(a.day);
        db = (23'(b.year) << 9) | (23'(b.month) << 5) | 23'(b.day);
        if (sort_key == KEY_DATE) begin
            return da < db;
        end
        return (a.id ^ 32'h8000_0000) < (b.id ^ 32'h8000_0000);
    endfunction

    // Insert one record; on a last beat, fill drain_beats with the sorted set
    function automatic void sort_insert(input t_rec r, input logic last);
        int pos;
        sorted_beat_t b;
        drain_beats.delete();
        if (held < MAX_RECORDS) begin
            pos = held;
            while (pos > 0 && rec_below(r, sorted_store[pos-1])) begin
                sorted_store[pos] = sorted_store[pos-1];
                pos--;
            end
            sorted_store[pos] = r;
            held++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < held; k++) begin
                b.tag   = sorted_store[k].tag;
                b.id    = sorted_store[k].id;
                b.year  = sorted_store[k].year;
                b.month = sorted_store[k].month;
                b.day   = sorted_store[k].day;
                b.ovf   = dropped;
                b.last  = (k + 1 == held);
                drain_beats.push_back(b);
            end
            held = 0;
            dropped = 1'b0;
        end
    endfunction

    function automatic stim_row_t rec_row(input logic [31:0] id, input int y, input int m,
                                          input int d, input int tag, input logic last);
        stim_row_t r;
        r.kind      = ROW_REC;
        r.rec.id    = id;
        r.rec.year  = y[13:0];
        r.rec.month = m[3:0];
        r.rec.day   = d[4:0];
        r.rec.tag   = tag[5:0];
        r.last      = last;
        r.key       = KEY_ID;
        r.typed     = 1'b0;
        r.exp       = '0;
        return r;
    endfunction

    function automatic stim_row_t key_row(input t_key k);
        stim_row_t r;
        r = rec_row(32'd0, 0, 0, 0, 0, 1'b0);
        r.kind = ROW_KEY;
        r.key  = k;
        return r;
    endfunction

    // Random record: tie-heavy pools mixed with full-range values
    function automatic t_rec rand_record();
        t_rec r;
        case ($urandom_range(3))
            0: r.id = 32'($urandom_range(7)) - 32'd4;
            1: begin
                case ($urandom_range(3))
                    0: r.id = 32'h8000_0000;
                    1: r.id = 32'h7FFF_FFFF;
                    2: r.id = 32'h0000_0000;
                    default: r.id = 32'hFFFF_FFFF;
                endcase
            end
            default: r.id = $urandom;
        endcase
        if ($urandom_range(1) == 1) begin
            r.year  = 14'd2000 + 14'($urandom_range(1));
            r.month = 4'($urandom_range(2));
            r.day   = 5'($urandom_range(3));
        end else begin
            r.year  = 14'($urandom_range(9999));
            r.month = 4'($urandom_range(15));
            r.day   = 5'($urandom_range(31));
        end
        r.tag = 6'($urandom_range(63));
        return r;
    endfunction

    // Present one record beat, wait for it to be taken, then predict
    task automatic send_record(input t_rec r, input logic last, input int idle_pct,
                               input bit typed, input sorted_beat_t typed_beat);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_student_id  <= r.id;
        i_year        <= r.year;
        i_month       <= r.month;
        i_day         <= r.day;
        i_record_tag  <= r.tag;
        i_last_record <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        sort_insert(r, last);
        if (typed) begin
            pending_sorted.push_back(typed_beat);
        end else begin
            foreach (drain_beats[k]) pending_sorted.push_back(drain_beats[k]);
        end
    endtask

    // Key write only once every pending beat is out and the chain has settled
    task automatic write_key(input t_key k);
        start <= 1'b0;
        while (pending_sorted.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        sort_key = k;
        i_cfg_we <= 1'b0;
    endtask

    // Output checker
    always @(posedge i_clk) begin
        sorted_beat_t got;
        sorted_beat_t want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            got = '{o_out_tag, o_out_id, o_out_year, o_out_month, o_out_day,
                    o_overflowed, o_out_last};
            if (pending_sorted.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected beat: tag=%0d id=%0d date=%0d/%0d/%0d ovf=%0b last=%0b",
                             got.tag, got.id, got.year, got.month, got.day, got.ovf, got.last);
                end
            end else begin
                want = pending_sorted.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("beat mismatch: got tag=%0d id=%0d date=%0d/%0d/%0d ovf=%0b last=%0b",
                                 got.tag, got.id, got.year, got.month, got.day,
                                 got.ovf, got.last);
                        $display("           expected tag=%0d id=%0d date=%0d/%0d/%0d ovf=%0b last=%0b",
                                 want.tag, want.id, want.year, want.month, want.day,
                                 want.ovf, want.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("record_insertion_sorter test failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        stim_row_t dir_rows [$];
        stim_row_t row;
        int set_left;
        int set_no;

        set_left = 0;
        set_no = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-record sets at the field extremes: the beat echoes the record
        row = rec_row(32'h8000_0000, 9999, 15, 31, 63, 1'b1);
        row.typed = 1'b1;
        row.exp = '{6'd63, 32'h8000_0000, 14'd9999, 4'd15, 5'd31, 1'b0, 1'b1};
        dir_rows.push_back(row);
        row = rec_row(32'h7FFF_FFFF, 0, 0, 0, 0, 1'b1);
        row.typed = 1'b1;
        row.exp = '{6'd0, 32'h7FFF_FFFF, 14'd0, 4'd0, 5'd0, 1'b0, 1'b1};
        dir_rows.push_back(row);

        // Id key: equal ids keep arrival order, signed extremes at both ends
        dir_rows.push_back(rec_row(32'd5, 10, 1, 1, 1, 1'b0));
        dir_rows.push_back(rec_row(-32'sd3, 20, 2, 2, 2, 1'b0));
        dir_rows.push_back(rec_row(32'd5, 5, 3, 3, 3, 1'b0));
        dir_rows.push_back(rec_row(32'h7FFF_FFFF, 0, 0, 0, 4, 1'b0));
        dir_rows.push_back(rec_row(32'h8000_0000, 9999, 15, 31, 5, 1'b0));
        dir_rows.push_back(rec_row(32'd5, 1, 1, 1, 6, 1'b1));

        // Date key: ties, year dominates month, out-of-range month and day
        dir_rows.push_back(key_row(KEY_DATE));
        dir_rows.push_back(rec_row(32'd1, 2024, 5, 3, 10, 1'b0));
        dir_rows.push_back(rec_row(32'd0, 2024, 5, 3, 11, 1'b0));
        dir_rows.push_back(rec_row(32'd9, 0, 0, 0, 12, 1'b0));
        dir_rows.push_back(rec_row(32'h8000_0000, 9999, 15, 31, 13, 1'b0));
        dir_rows.push_back(rec_row(-32'sd7, 2023, 15, 31, 14, 1'b0));
        dir_rows.push_back(rec_row(32'd3, 2024, 0, 0, 15, 1'b0));
        dir_rows.push_back(rec_row(32'd2, 2024, 5, 2, 16, 1'b1));

        // Key switched mid-set: stored entries stay, new one placed by id
        dir_rows.push_back(rec_row(32'd100, 9999, 1, 1, 20, 1'b0));
        dir_rows.push_back(rec_row(-32'sd100, 0, 1, 1, 21, 1'b0));
        dir_rows.push_back(key_row(KEY_ID));
        dir_rows.push_back(rec_row(32'd0, 5000, 6, 6, 22, 1'b1));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_KEY) begin
                write_key(dir_rows[i].key);
            end else begin
                send_record(dir_rows[i].rec, dir_rows[i].last, 0,
                            dir_rows[i].typed, dir_rows[i].exp);
            end
        end

        // Random phases; sets may straddle a phase and so see a key change
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 4) begin
                write_key((ph % 2 == 0) ? KEY_DATE : KEY_ID);
            end else begin
                write_key(t_key'($urandom_range(1)));
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (set_left == 0) begin
                    if (set_no == 0) begin
                        set_left = MAX_RECORDS + 6;
                    end else if (set_no == 6) begin
                        set_left = MAX_RECORDS;
                    end else if ($urandom_range(11) == 0) begin
                        set_left = $urandom_range(MAX_RECORDS + 8, MAX_RECORDS - 4);
                    end else begin
                        set_left = $urandom_range(10, 1);
                    end
                    set_no++;
                end
                send_record(rand_record(), set_left == 1,
                            (ph % 3 == 1) ? 73 : ((ph % 3 == 2) ? 18 : 0), 1'b0, '0);
                set_left--;
            end
        end

        // Close the open set so its records drain
        while (set_left > 0) begin
            send_record(rand_record(), set_left == 1, 0, 1'b0, '0);
            set_left--;
        end

        // Drain and let any stray beat show up
        start <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("record_insertion_sorter test passed");
        end else begin
            $display("record_insertion_sorter test failed");
        end
        $finish;
    end

endmodule
